// ===== sv/assert_macros.svh =====
// assertion helpers used by the step core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is active
`define MDB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked check that also holds during reset
`define MDB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/mdb_pkg.sv =====
// ----------------------------------------------------------------------------
// mdb_pkg
// Types and fixed constants of the death-birth step core: field widths,
// configuration register indexes, reset values and the Q2.14 unit.
// ----------------------------------------------------------------------------
package mdb_pkg;

    // field widths
    localparam int RAND_W     = 16;
    localparam int NODE_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int EPS_W      = 15;
    localparam int FIT_W      = 16;
    localparam int PROB_W     = 17;
    localparam int WEIGHT_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // one in Q2.14
    localparam logic [WEIGHT_W-1:0] ONE_Q14 = 16'd16384;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT   = 3'd0,
        CFG_EPSILON      = 3'd1,
        CFG_FIT_RESIDENT = 3'd2,
        CFG_FIT_MUTANT   = 3'd3,
        CFG_STAY_HIGH    = 3'd4,
        CFG_RISE         = 3'd5
    } t_cfg_idx;

    // register reset values
    localparam logic [COUNT_W-1:0] RST_NODE_COUNT = 7'd64;
    localparam logic [EPS_W-1:0]   RST_EPSILON    = 15'd0;
    localparam logic [FIT_W-1:0]   RST_FITNESS    = 16'd16384;
    localparam logic [PROB_W-1:0]  RST_PROB       = 17'd32768;

endpackage

// ===== sv/moran_death_birth_step_core.sv =====
// ----------------------------------------------------------------------------
// moran_death_birth_step_core
// One Monte Carlo step of a death-birth Moran process on a complete graph.
// Node types live in a one-bit RAM; each update scans it to build roulette
// totals and prefix sums for the death and the birth draw.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   mode, start node, noise, randoms
//   output    out        o_valid / i_stall   mutant count, flags, nodes, noise
//   config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// Update item: three serial scans of the node RAM do the work: totals,
// death prefix, birth prefix; the prefix scans stop at the selected node.
// An absorbed update skips the scans. Start item: the whole RAM is cleared,
// one RAM entry cleared per cycle, then the start node is marked if in use.
// After reset a clearing pass runs before the first input transfer; config
// writes are taken throughout.
// A stalled result waits in the output register; the next item is already
// accepted and finishes into a hold state until the register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module moran_death_birth_step_core #(
    parameter int MAX_NODES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [mdb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mdb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_mode,
    input  logic [mdb_pkg::NODE_W-1:0]      i_start_node,
    input  logic                            i_initial_noise_high,
    input  logic [mdb_pkg::RAND_W-1:0]      i_rand_death,
    input  logic [mdb_pkg::RAND_W-1:0]      i_rand_birth,
    input  logic [mdb_pkg::RAND_W-1:0]      i_rand_noise,
    input  logic                            i_sign_resident_draw,
    input  logic                            i_sign_mutant_draw,
    // output channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [mdb_pkg::COUNT_W-1:0]     o_mutant_count,
    output logic                            o_fixed_flag,
    output logic                            o_lost_flag,
    output logic [mdb_pkg::NODE_W-1:0]      o_dead_node,
    output logic [mdb_pkg::NODE_W-1:0]      o_parent_node,
    output logic                            o_noise_now_high
);

    import mdb_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = (NW + 1 > COUNT_W) ? NW + 1 : COUNT_W;
    localparam int TW = WEIGHT_W + NW;
    localparam int PW = TW + RAND_W;
    localparam logic [NW-1:0] LAST_ADDR = NW'(MAX_NODES - 1);
    localparam logic [CW-1:0] N_MAX     = CW'(MAX_NODES);
    localparam logic [CW-1:0] N_MIN     = CW'(2);

    typedef enum logic [3:0] {
        S_CLEAR, S_MARK, S_IDLE, S_TOTAL, S_DMUL, S_DEATH,
        S_BTOT, S_BMUL, S_BIRTH, S_WRITE, S_DONE
    } t_state;

    t_state r_state;

    // configuration registers
    logic [COUNT_W-1:0] r_node_count;
    logic [EPS_W-1:0]   r_eps;
    logic [FIT_W-1:0]   r_fit_res;
    logic [FIT_W-1:0]   r_fit_mut;
    logic [PROB_W-1:0]  r_stay_high;
    logic [PROB_W-1:0]  r_rise;

    // process state held in registers
    logic [CW-1:0] r_mut_total;
    logic          r_noise;
    logic          r_sgn_res;
    logic          r_sgn_mut;

    // latched input item
    logic              r_start_pend;
    logic [NODE_W-1:0] r_start;
    logic              r_init_noise;
    logic [RAND_W-1:0] r_rd;
    logic [RAND_W-1:0] r_rb;
    logic [RAND_W-1:0] r_rn;
    logic              r_sr_in;
    logic              r_sm_in;

    // scan and roulette datapath
    logic [NW-1:0] r_clr;
    logic [NW-1:0] r_scan_addr;
    logic          r_scan_on;
    logic          r_pv;
    logic [NW-1:0] r_pidx;
    logic [TW-1:0] r_tot_d;
    logic [TW-1:0] r_tot_b;
    logic [TW-1:0] r_prefix;
    logic [PW-1:0] r_rt;
    logic [NW-1:0] r_dead;
    logic          r_dead_t;
    logic [NW-1:0] r_parent;
    logic          r_par_t;
    logic [NW-1:0] r_last_idx;
    logic          r_last_t;

    // output register
    logic               r_o_vld;
    logic [COUNT_W-1:0] r_o_count;
    logic               r_o_fixed;
    logic               r_o_lost;
    logic [NODE_W-1:0]  r_o_dead;
    logic [NODE_W-1:0]  r_o_parent;
    logic               r_o_noise;

    // ram ports
    logic          ram_we;
    logic [NW-1:0] ram_waddr;
    logic          ram_wdata;
    logic          ram_rdata;

    // combinational helpers
    logic [CW-1:0]       n_use;
    logic [CW-1:0]       n_last;
    logic [CW-1:0]       start_ext;
    logic                start_ok;
    logic                absorbed;
    logic                scan_at_end;
    logic                pidx_at_end;
    logic [WEIGHT_W-1:0] wd_plus;
    logic [WEIGHT_W-1:0] wd_minus;
    logic [WEIGHT_W-1:0] wd_res;
    logic [WEIGHT_W-1:0] wd_mut;
    logic [WEIGHT_W-1:0] wd_cur;
    logic [WEIGHT_W-1:0] wb_cur;
    logic [WEIGHT_W-1:0] wb_dead;
    logic                elig;
    logic [TW-1:0]       pre_d;
    logic [TW-1:0]       pre_b;
    logic                hit_d;
    logic                hit_b;
    logic                noise_next;
    logic [CW-1:0]       dead_ext;
    logic [CW-1:0]       parent_ext;
    logic                in_xfer;
    logic                out_free;

    // nodes in use, clamped to [2, MAX_NODES]
    always_comb begin
        if (CW'(r_node_count) < N_MIN) begin
            n_use = N_MIN;
        end else if (CW'(r_node_count) > N_MAX) begin
            n_use = N_MAX;
        end else begin
            n_use = CW'(r_node_count);
        end
    end

    assign n_last      = n_use - CW'(1);
    assign start_ext   = CW'(r_start);
    assign start_ok    = start_ext < n_use;
    assign absorbed    = (r_mut_total == '0) || (r_mut_total >= n_use);
    assign scan_at_end = CW'(r_scan_addr) == n_last;
    assign pidx_at_end = CW'(r_pidx) == n_last;

    // death and birth weights of the node on the read port
    assign wd_plus  = ONE_Q14 + WEIGHT_W'(r_eps);
    assign wd_minus = (WEIGHT_W'(r_eps) >= ONE_Q14) ? '0 : ONE_Q14 - WEIGHT_W'(r_eps);
    assign wd_res   = r_sgn_res ? wd_plus : wd_minus;
    assign wd_mut   = r_sgn_mut ? wd_plus : wd_minus;
    assign wd_cur   = ram_rdata ? wd_mut : wd_res;
    assign wb_cur   = ram_rdata ? r_fit_mut : r_fit_res;
    assign wb_dead  = r_dead_t ? r_fit_mut : r_fit_res;

    // roulette tests against the scaled prefix
    assign elig  = r_pidx != r_dead;
    assign pre_d = r_prefix + TW'(wd_cur);
    assign pre_b = r_prefix + (elig ? TW'(wb_cur) : '0);
    assign hit_d = r_rt <= {pre_d, {RAND_W{1'b0}}};
    assign hit_b = elig && (r_rt <= {pre_b, {RAND_W{1'b0}}});

    // telegraph noise transition
    assign noise_next = r_noise ? (PROB_W'(r_rn) <= r_stay_high)
                                : (PROB_W'(r_rn) <= r_rise);

    assign dead_ext   = CW'(r_dead);
    assign parent_ext = CW'(r_parent);

    assign o_stall  = r_state != S_IDLE;
    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_o_vld || !i_stall;

    // ram write port: clearing sweep, start mark, copy of parent type
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_dead;
        ram_wdata = r_par_t;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = 1'b0;
            end
            S_MARK: begin
                ram_we    = start_ok;
                ram_waddr = start_ext[NW-1:0];
                ram_wdata = 1'b1;
            end
            S_WRITE: begin
                ram_we    = 1'b1;
            end
            default: begin
                ram_we    = 1'b0;
            end
        endcase
    end

    mdb_ram #(
        .WIDTH (1),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_scan_addr),
        .o_rdata (ram_rdata)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= RST_NODE_COUNT;
            r_eps        <= RST_EPSILON;
            r_fit_res    <= RST_FITNESS;
            r_fit_mut    <= RST_FITNESS;
            r_stay_high  <= RST_PROB;
            r_rise       <= RST_PROB;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NODE_COUNT:   r_node_count <= i_cfg_data[COUNT_W-1:0];
                CFG_EPSILON:      r_eps        <= i_cfg_data[EPS_W-1:0];
                CFG_FIT_RESIDENT: r_fit_res    <= i_cfg_data[FIT_W-1:0];
                CFG_FIT_MUTANT:   r_fit_mut    <= i_cfg_data[FIT_W-1:0];
                CFG_STAY_HIGH:    r_stay_high  <= i_cfg_data[PROB_W-1:0];
                CFG_RISE:         r_rise       <= i_cfg_data[PROB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer, scan pipeline and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_start_pend <= 1'b0;
            r_scan_on    <= 1'b0;
            r_scan_addr  <= '0;
            r_pv         <= 1'b0;
            r_mut_total  <= '0;
            r_noise      <= 1'b0;
            r_sgn_res    <= 1'b0;
            r_sgn_mut    <= 1'b0;
            r_o_vld      <= 1'b0;
        end else begin
            // read pipeline: data arrives in the cycle after its address
            r_pv   <= r_scan_on;
            r_pidx <= r_scan_addr;
            if (r_scan_on) begin
                if (scan_at_end) begin
                    r_scan_on <= 1'b0;
                end else begin
                    r_scan_addr <= r_scan_addr + NW'(1);
                end
            end

            // output transfer frees the register
            if (r_o_vld && !i_stall) begin
                r_o_vld <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + NW'(1);
                    if (r_clr == LAST_ADDR) begin
                        r_state <= r_start_pend ? S_MARK : S_IDLE;
                    end
                end
                S_MARK: begin
                    r_start_pend <= 1'b0;
                    r_mut_total  <= start_ok ? CW'(1) : '0;
                    r_noise      <= r_init_noise;
                    r_sgn_res    <= r_sr_in;
                    r_sgn_mut    <= r_sm_in;
                    r_dead       <= '0;
                    r_parent     <= '0;
                    r_state      <= S_DONE;
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_start      <= i_start_node;
                        r_init_noise <= i_initial_noise_high;
                        r_rd         <= i_rand_death;
                        r_rb         <= i_rand_birth;
                        r_rn         <= i_rand_noise;
                        r_sr_in      <= i_sign_resident_draw;
                        r_sm_in      <= i_sign_mutant_draw;
                        r_dead       <= '0;
                        r_parent     <= '0;
                        if (!i_mode) begin
                            r_start_pend <= 1'b1;
                            r_clr        <= '0;
                            r_state      <= S_CLEAR;
                        end else if (absorbed) begin
                            r_state <= S_DONE;
                        end else begin
                            r_tot_d     <= '0;
                            r_tot_b     <= '0;
                            r_scan_addr <= '0;
                            r_scan_on   <= 1'b1;
                            r_state     <= S_TOTAL;
                        end
                    end
                end
                // totals of death and birth weights over all nodes in use
                S_TOTAL: begin
                    if (r_pv) begin
                        r_tot_d <= r_tot_d + TW'(wd_cur);
                        r_tot_b <= r_tot_b + TW'(wb_cur);
                        if (pidx_at_end) begin
                            r_state <= S_DMUL;
                        end
                    end
                end
                S_DMUL: begin
                    r_rt        <= PW'(r_rd) * PW'(r_tot_d);
                    r_prefix    <= '0;
                    r_scan_addr <= '0;
                    r_scan_on   <= 1'b1;
                    r_state     <= S_DEATH;
                end
                // death roulette, last node takes a rounding overrun
                S_DEATH: begin
                    if (r_pv) begin
                        r_prefix <= pre_d;
                        if (hit_d || pidx_at_end) begin
                            r_dead    <= r_pidx;
                            r_dead_t  <= ram_rdata;
                            r_scan_on <= 1'b0;
                            r_state   <= S_BTOT;
                        end
                    end
                end
                // birth total without the dying node
                S_BTOT: begin
                    r_tot_b <= r_tot_b - TW'(wb_dead);
                    r_state <= S_BMUL;
                end
                S_BMUL: begin
                    r_rt        <= PW'(r_rb) * PW'(r_tot_b);
                    r_prefix    <= '0;
                    r_scan_addr <= '0;
                    r_scan_on   <= 1'b1;
                    r_state     <= S_BIRTH;
                end
                // birth roulette over the other nodes
                S_BIRTH: begin
                    if (r_pv) begin
                        r_prefix <= pre_b;
                        if (hit_b) begin
                            r_parent  <= r_pidx;
                            r_par_t   <= ram_rdata;
                            r_scan_on <= 1'b0;
                            r_state   <= S_WRITE;
                        end else if (pidx_at_end) begin
                            r_parent  <= elig ? r_pidx : r_last_idx;
                            r_par_t   <= elig ? ram_rdata : r_last_t;
                            r_scan_on <= 1'b0;
                            r_state   <= S_WRITE;
                        end else if (elig) begin
                            r_last_idx <= r_pidx;
                            r_last_t   <= ram_rdata;
                        end
                    end
                end
                // copy parent type, count mutants, advance noise
                S_WRITE: begin
                    if (r_par_t && !r_dead_t) begin
                        r_mut_total <= r_mut_total + CW'(1);
                    end else if (!r_par_t && r_dead_t) begin
                        r_mut_total <= r_mut_total - CW'(1);
                    end
                    r_noise <= noise_next;
                    if (noise_next != r_noise) begin
                        r_sgn_res <= r_sr_in;
                        r_sgn_mut <= r_sm_in;
                    end
                    r_state <= S_DONE;
                end
                // hold until the output register is free
                S_DONE: begin
                    if (out_free) begin
                        r_o_vld    <= 1'b1;
                        r_o_count  <= r_mut_total[COUNT_W-1:0];
                        r_o_fixed  <= r_mut_total >= n_use;
                        r_o_lost   <= r_mut_total == '0;
                        r_o_dead   <= dead_ext[NODE_W-1:0];
                        r_o_parent <= parent_ext[NODE_W-1:0];
                        r_o_noise  <= r_noise;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_o_vld;
    assign o_mutant_count   = r_o_count;
    assign o_fixed_flag     = r_o_fixed;
    assign o_lost_flag      = r_o_lost;
    assign o_dead_node      = r_o_dead;
    assign o_parent_node    = r_o_parent;
    assign o_noise_now_high = r_o_noise;

    // checks on the sequencer and datapath
    `MDB_ASSERT(a_dead_in_range, i_clk, i_rst_n, (r_state == S_BTOT) |-> (dead_ext < n_use), "dead node outside nodes in use")
    `MDB_ASSERT(a_parent_not_dead, i_clk, i_rst_n, (r_state == S_WRITE) |-> (r_parent != r_dead), "parent equals dying node")
    `MDB_ASSERT(a_count_steady, i_clk, i_rst_n, (r_state != S_WRITE && r_state != S_MARK) |=> $stable(r_mut_total), "mutant total changed outside update")
    `MDB_ASSERT(a_no_scan_at_accept, i_clk, i_rst_n, in_xfer |-> (!r_scan_on && !r_start_pend), "input transfer while node scan active")

endmodule

// ===== sv/mdb_ram.sv =====
// ----------------------------------------------------------------------------
// mdb_ram
// Generic single-clock RAM, one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
module mdb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== verif/mdb_step_checker.sv =====
// ----------------------------------------------------------------------------
// mdb_step_checker
// Watches both channels and the config port of the death-birth step core,
// keeps its own copy of the node types, noise state and registers, predicts
// one outcome per accepted item and compares every returned result with it.
// ----------------------------------------------------------------------------
module mdb_step_checker #(
    parameter int MAX_NODES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config port as seen by the block
    input  logic                            i_cfg_we,
    input  logic [mdb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mdb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic                            i_mode,
    input  logic [mdb_pkg::NODE_W-1:0]      i_start_node,
    input  logic                            i_initial_noise_high,
    input  logic [mdb_pkg::RAND_W-1:0]      i_rand_death,
    input  logic [mdb_pkg::RAND_W-1:0]      i_rand_birth,
    input  logic [mdb_pkg::RAND_W-1:0]      i_rand_noise,
    input  logic                            i_sign_resident_draw,
    input  logic                            i_sign_mutant_draw,
    // output channel
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [mdb_pkg::COUNT_W-1:0]     i_mutant_count,
    input  logic                            i_fixed_flag,
    input  logic                            i_lost_flag,
    input  logic [mdb_pkg::NODE_W-1:0]      i_dead_node,
    input  logic [mdb_pkg::NODE_W-1:0]      i_parent_node,
    input  logic                            i_noise_now_high,
    // status for the top
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mdb_pkg::*;

    localparam logic MODE_START = 1'b0;
    localparam int   PRINT_CAP  = 100;

    typedef struct {
        logic [COUNT_W-1:0] mutant_count;
        logic               fixed_flag;
        logic               lost_flag;
        logic [NODE_W-1:0]  dead_node;
        logic [NODE_W-1:0]  parent_node;
        logic               noise_high;
    } t_outcome;

    // population state
    bit          mutant_map [MAX_NODES];
    int unsigned population;
    bit          noise_state;
    bit          res_sign;
    bit          mut_sign;

    // register copies
    logic [COUNT_W-1:0] nodes_reg;
    logic [EPS_W-1:0]   eps_reg;
    logic [FIT_W-1:0]   fit_res_reg;
    logic [FIT_W-1:0]   fit_mut_reg;
    logic [PROB_W-1:0]  stay_reg;
    logic [PROB_W-1:0]  rise_reg;

    t_outcome pending_outcomes [$];
    int       outstanding;
    int       fail_total;
    int       result_idx;

    assign o_fail_count = fail_total;
    assign o_pending    = outstanding;

    task automatic flag_mismatch(input string msg);
        // keep the log short when the block is badly off
        if (fail_total < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
        fail_total++;
    endtask

    function automatic int unsigned nodes_in_play();
        int unsigned n;
        n = nodes_reg;
        if (n < 2) n = 2;
        if (n > MAX_NODES) n = MAX_NODES;
        return n;
    endfunction

    // death weight is 1 +/- eps, saturated at zero; birth weight is the fitness
    function automatic longint unsigned node_weight(input int unsigned node, input bit birth);
        bit sgn;
        if (birth) return mutant_map[node] ? 64'(fit_mut_reg) : 64'(fit_res_reg);
        sgn = mutant_map[node] ? mut_sign : res_sign;
        if (sgn) return 64'(ONE_Q14) + 64'(eps_reg);
        if (eps_reg >= ONE_Q14) return 64'd0;
        return 64'(ONE_Q14) - 64'(eps_reg);
    endfunction

    // first node with rnd * total <= prefix * 65536, else the last eligible one
    function automatic int unsigned spin_roulette(input int unsigned n, input int unsigned skip,
                                                  input bit birth,
                                                  input logic [RAND_W-1:0] rnd);
        longint unsigned total;
        longint unsigned acc;
        int unsigned     last;
        int unsigned     i;
        total = 0;
        acc   = 0;
        last  = 0;
        for (i = 0; i < n; i++) begin
            if (i != skip) total += node_weight(i, birth);
        end
        for (i = 0; i < n; i++) begin
            if (i != skip) begin
                last = i;
                acc += node_weight(i, birth);
                if (64'(rnd) * total <= acc * 64'd65536) return i;
            end
        end
        return last;
    endfunction

    // apply one accepted item and queue the outcome it must produce
    task automatic advance_population();
        int unsigned n;
        int unsigned dead;
        int unsigned parent;
        bit          was_high;
        t_outcome    res;
        n      = nodes_in_play();
        dead   = 0;
        parent = 0;
        if (i_mode == MODE_START) begin
            foreach (mutant_map[k]) mutant_map[k] = 1'b0;
            population = 0;
            if (i_start_node < n) begin
                mutant_map[i_start_node] = 1'b1;
                population = 1;
            end
            noise_state = i_initial_noise_high;
            res_sign    = i_sign_resident_draw;
            mut_sign    = i_sign_mutant_draw;
        end else if (population != 0 && population < n) begin
            dead   = spin_roulette(n, n, 1'b0, i_rand_death);
            parent = spin_roulette(n, dead, 1'b1, i_rand_birth);
            if (mutant_map[parent] && !mutant_map[dead]) population++;
            else if (!mutant_map[parent] && mutant_map[dead]) population--;
            mutant_map[dead] = mutant_map[parent];
            // telegraph noise, signs redrawn on a flip
            was_high    = noise_state;
            noise_state = noise_state ? (i_rand_noise <= stay_reg) : (i_rand_noise <= rise_reg);
            if (noise_state != was_high) begin
                res_sign = i_sign_resident_draw;
                mut_sign = i_sign_mutant_draw;
            end
        end
        res.mutant_count = population[COUNT_W-1:0];
        res.fixed_flag   = (population >= n);
        res.lost_flag    = (population == 0);
        res.dead_node    = dead[NODE_W-1:0];
        res.parent_node  = parent[NODE_W-1:0];
        res.noise_high   = noise_state;
        pending_outcomes.push_back(res);
        outstanding++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s: got %0d expected %0d",
                                    result_idx, name, got, want));
    endtask

    task automatic check_outcome();
        t_outcome want;
        if (pending_outcomes.size() == 0) begin
            flag_mismatch($sformatf("result %0d arrived with nothing expected", result_idx));
        end else begin
            want = pending_outcomes.pop_front();
            outstanding--;
            compare_field("mutant_count", 16'(i_mutant_count), 16'(want.mutant_count));
            compare_field("fixed_flag", 16'(i_fixed_flag), 16'(want.fixed_flag));
            compare_field("lost_flag", 16'(i_lost_flag), 16'(want.lost_flag));
            compare_field("dead_node", 16'(i_dead_node), 16'(want.dead_node));
            compare_field("parent_node", 16'(i_parent_node), 16'(want.parent_node));
            compare_field("noise_now_high", 16'(i_noise_now_high), 16'(want.noise_high));
        end
        result_idx++;
    endtask

    // results first, then the new item, then register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (mutant_map[k]) mutant_map[k] = 1'b0;
            population  = 0;
            noise_state = 1'b0;
            res_sign    = 1'b0;
            mut_sign    = 1'b0;
            nodes_reg   = RST_NODE_COUNT;
            eps_reg     = RST_EPSILON;
            fit_res_reg = RST_FITNESS;
            fit_mut_reg = RST_FITNESS;
            stay_reg    = RST_PROB;
            rise_reg    = RST_PROB;
            outstanding = 0;
            fail_total  = 0;
            result_idx  = 0;
        end else begin
            if (i_out_valid && !i_out_stall) check_outcome();
            if (i_in_valid && !i_in_stall) advance_population();
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_NODE_COUNT:   nodes_reg   = i_cfg_data[COUNT_W-1:0];
                    CFG_EPSILON:      eps_reg     = i_cfg_data[EPS_W-1:0];
                    CFG_FIT_RESIDENT: fit_res_reg = i_cfg_data[FIT_W-1:0];
                    CFG_FIT_MUTANT:   fit_mut_reg = i_cfg_data[FIT_W-1:0];
                    CFG_STAY_HIGH:    stay_reg    = i_cfg_data[PROB_W-1:0];
                    CFG_RISE:         rise_reg    = i_cfg_data[PROB_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== verif/tb_moran_death_birth_step_core.sv =====
// ----------------------------------------------------------------------------
// tb_moran_death_birth_step_core
// Drives the death-birth step core through directed trials and randomized
// phases under several register settings, with random idle cycles on both
// channels and long output hold-offs; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_moran_death_birth_step_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mdb_pkg::*;

    localparam int   MAX_NODES      = 64;
    localparam logic MODE_START     = 1'b0;
    localparam logic MODE_UPDATE    = 1'b1;
    localparam int   IDLE_PCT       = 35;
    localparam int   HOLD_CYCLES    = 400;
    localparam int   WATCHDOG_LIMIT = 5000;
    localparam int   SETTLE_CYCLES  = 8;
    localparam int   DRAIN_CYCLES   = 300;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_mode;
    logic [NODE_W-1:0]     i_start_node;
    logic                  i_initial_noise_high;
    logic [RAND_W-1:0]     i_rand_death;
    logic [RAND_W-1:0]     i_rand_birth;
    logic [RAND_W-1:0]     i_rand_noise;
    logic                  i_sign_resident_draw;
    logic                  i_sign_mutant_draw;
    logic                  o_valid;
    logic                  i_stall;
    logic [COUNT_W-1:0]    o_mutant_count;
    logic                  o_fixed_flag;
    logic                  o_lost_flag;
    logic [NODE_W-1:0]     o_dead_node;
    logic [NODE_W-1:0]     o_parent_node;
    logic                  o_noise_now_high;

    int fail_count;
    int pending_count;
    int stuck_cycles;
    bit idle_on;
    int cur_nodes;
    int updates_left;

    moran_death_birth_step_core #(.MAX_NODES(MAX_NODES)) dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_mode               (i_mode),
        .i_start_node         (i_start_node),
        .i_initial_noise_high (i_initial_noise_high),
        .i_rand_death         (i_rand_death),
        .i_rand_birth         (i_rand_birth),
        .i_rand_noise         (i_rand_noise),
        .i_sign_resident_draw (i_sign_resident_draw),
        .i_sign_mutant_draw   (i_sign_mutant_draw),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_mutant_count       (o_mutant_count),
        .o_fixed_flag         (o_fixed_flag),
        .o_lost_flag          (o_lost_flag),
        .o_dead_node          (o_dead_node),
        .o_parent_node        (o_parent_node),
        .o_noise_now_high     (o_noise_now_high)
    );

    mdb_step_checker #(.MAX_NODES(MAX_NODES)) u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_valid),
        .i_in_stall           (o_stall),
        .i_mode               (i_mode),
        .i_start_node         (i_start_node),
        .i_initial_noise_high (i_initial_noise_high),
        .i_rand_death         (i_rand_death),
        .i_rand_birth         (i_rand_birth),
        .i_rand_noise         (i_rand_noise),
        .i_sign_resident_draw (i_sign_resident_draw),
        .i_sign_mutant_draw   (i_sign_mutant_draw),
        .i_out_valid          (o_valid),
        .i_out_stall          (i_stall),
        .i_mutant_count       (o_mutant_count),
        .i_fixed_flag         (o_fixed_flag),
        .i_lost_flag          (o_lost_flag),
        .i_dead_node          (o_dead_node),
        .i_parent_node        (o_parent_node),
        .i_noise_now_high     (o_noise_now_high),
        .o_fail_count         (fail_count),
        .o_pending            (pending_count)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // result side: random stall, plus long hold-offs that fill the block
    initial begin
        int results;
        int next_hold;
        results   = 0;
        next_hold = 150;
        i_stall   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) results++;
            @(negedge i_clk);
            if (results >= next_hold) begin
                next_hold = (next_hold == 150) ? 1200 : 32'h7fff_ffff;
                i_stall   = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_stall = idle_on && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    function automatic logic [RAND_W-1:0] pick_rand();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return RAND_W'($urandom_range(65535));
        endcase
    endfunction

    // one input transfer; called and returning at a falling edge
    task automatic offer_item(input logic mode, input logic [NODE_W-1:0] start,
                              input logic noise0, input logic [RAND_W-1:0] rd,
                              input logic [RAND_W-1:0] rb, input logic [RAND_W-1:0] rn,
                              input logic sr, input logic sm);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_mode               = mode;
        i_start_node         = start;
        i_initial_noise_high = noise0;
        i_rand_death         = rd;
        i_rand_birth         = rb;
        i_rand_noise         = rn;
        i_sign_resident_draw = sr;
        i_sign_mutant_draw   = sm;
        i_valid              = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = CFG_DATA_W'(value);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // registers change only once every result is back
    task automatic set_config(input int unsigned nodes, input int unsigned eps,
                              input int unsigned fit_res, input int unsigned fit_mut,
                              input int unsigned stay, input int unsigned rise);
        i_valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg(CFG_NODE_COUNT, nodes);
        write_reg(CFG_EPSILON, eps);
        write_reg(CFG_FIT_RESIDENT, fit_res);
        write_reg(CFG_FIT_MUTANT, fit_mut);
        write_reg(CFG_STAY_HIGH, stay);
        write_reg(CFG_RISE, rise);
        cur_nodes = (nodes < 2) ? 2 : (nodes > MAX_NODES) ? MAX_NODES : nodes;
    endtask

    // trials: a start followed by a random run of updates, with some noise
    task automatic run_trials(input int count, input int max_run);
        int               k;
        logic [NODE_W-1:0] node;
        for (k = 0; k < count; k++) begin
            if (updates_left == 0 || $urandom_range(99) < 3) begin
                node = ($urandom_range(99) < 85) ? NODE_W'($urandom_range(cur_nodes - 1))
                                                 : NODE_W'($urandom_range(63));
                offer_item(MODE_START, node, 1'($urandom_range(1)), pick_rand(),
                           pick_rand(), pick_rand(), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
                updates_left = $urandom_range(max_run, 1);
            end else begin
                offer_item(MODE_UPDATE, NODE_W'($urandom_range(63)), 1'($urandom_range(1)),
                           pick_rand(), pick_rand(), pick_rand(), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
                updates_left--;
            end
        end
    endtask

    initial begin
        int k;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        i_valid              = 1'b0;
        i_mode               = MODE_START;
        i_start_node         = '0;
        i_initial_noise_high = 1'b0;
        i_rand_death         = '0;
        i_rand_birth         = '0;
        i_rand_noise         = '0;
        i_sign_resident_draw = 1'b0;
        i_sign_mutant_draw   = 1'b0;
        idle_on              = 1'b1;
        cur_nodes            = MAX_NODES;
        updates_left         = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // four nodes, death weight 1-eps saturates to zero, residents never give birth
        set_config(4, 16384, 0, 32768, 0, 65536);
        offer_item(MODE_UPDATE, 6'd5, 1'b1, 16'h1234, 16'h4321, 16'h0f0f, 1'b1, 1'b1);
        offer_item(MODE_START, 6'd63, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b1);
        offer_item(MODE_START, 6'd0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'h8000, 16'h8000, 16'h0000, 1'b1, 1'b0);
        offer_item(MODE_START, 6'd3, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'hffff, 16'hffff, 16'hffff, 1'b0, 1'b1);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'h0000, 16'h0000, 16'hffff, 1'b1, 1'b0);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'hffff, 16'hffff, 16'h0000, 1'b0, 1'b1);
        offer_item(MODE_START, 6'd2, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'hffff, 16'hffff, 16'h0001, 1'b0, 1'b1);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'h5555, 16'haaaa, 16'h0001, 1'b1, 1'b1);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'haaaa, 16'h5555, 16'h7fff, 1'b0, 1'b0);

        // node count below the clamp, eps beyond one, mutants never give birth
        set_config(0, 32767, 65535, 0, 131071, 0);
        offer_item(MODE_START, 6'd1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'h0000, 16'hffff, 16'hffff, 1'b1, 1'b0);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'hffff, 16'h0000, 16'h0000, 1'b1, 1'b1);
        offer_item(MODE_START, 6'd5, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'h1111, 16'h2222, 16'h3333, 1'b0, 1'b0);
        offer_item(MODE_START, 6'd0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'h8000, 16'hffff, 16'hffff, 1'b0, 1'b1);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'h0001, 16'h0001, 16'h0000, 1'b1, 1'b1);

        // node count above the clamp while a trial is still open
        set_config(127, 0, 16384, 16384, 65536, 0);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'hffff, 16'h0000, 16'hffff, 1'b1, 1'b1);
        offer_item(MODE_START, 6'd63, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
        offer_item(MODE_UPDATE, 6'd0, 1'b0, 16'hffff, 16'hffff, 16'hffff, 1'b0, 1'b0);

        // randomized phases
        set_config(8, 8000, 16384, 24576, 49152, 16384);
        run_trials(260, 40);
        idle_on = 1'b0;
        set_config(64, 0, 16384, 32768, 65536, 0);
        run_trials(200, 150);
        idle_on = 1'b1;
        set_config(3, 16384, 0, 0, 0, 65536);
        run_trials(180, 20);
        for (k = 0; k < 6; k++) begin
            set_config((k == 5) ? $urandom_range(127) : $urandom_range(16, 2),
                       $urandom_range(16384), $urandom_range(32768), $urandom_range(32768),
                       $urandom_range(65536), $urandom_range(65536));
            run_trials(215, 60);
        end

        // drain and verdict
        i_valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/mdb_pkg.sv
sv/mdb_ram.sv
sv/moran_death_birth_step_core.sv
verif/mdb_step_checker.sv
verif/tb_moran_death_birth_step_core.sv
